// ===== design/assert_macros.svh =====
// Assertion macros used by the positional list top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define AST_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pol_pkg.sv =====
// Package with sizes, codes and cell control types for the positional list.
package pol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int POS_W    = 5;
  localparam int VAL_W    = 32;
  localparam int ST_W     = 3;
  localparam int OUT_W    = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SEARCH   = 3'd6;
  localparam logic [CMD_W-1:0] CMD_REVERSE  = 3'd7;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_INS,
    CO_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [IDX_W-1:0]     slot;
    logic [VAL_W-1:0]     value;
  } cell_ctl_t;

endpackage

// ===== design/pol_cell.sv =====
// One storage cell of the list chain: holds an entry, shifts, and compares.
module pol_cell (
  input  logic                      clk,
  input  pol_pkg::cell_ctl_t        ctl,
  input  logic [pol_pkg::IDX_W-1:0] idx,
  input  logic [pol_pkg::VAL_W-1:0] left,
  input  logic [pol_pkg::VAL_W-1:0] right,
  output logic [pol_pkg::VAL_W-1:0] entry,
  output logic                      eq
);
  import pol_pkg::*;

  logic [VAL_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CO_INS: begin
        if (idx == ctl.slot) begin
          entry_next = ctl.value;
        end else if (idx > ctl.slot) begin
          entry_next = left;
        end
      end
      CO_DEL: begin
        if (idx >= ctl.slot) begin
          entry_next = right;
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign eq = (entry == ctl.value);

endmodule

// ===== design/positional_ordered_list.sv =====
// Top level of the positional ordered list: command decode, count, cell chain and search.
// An accepted command passes the execute state, then shows its result with done in the
// result state, where a new command can already be taken. Execute shifts the cell chain and
// registers all compares; the result state priority-encodes the match and shows the beat.
// Reset (synchronous, rst high) empties the list and clears the orientation mark.
// The receiver cannot stall: each result is shown for exactly one cycle with done.
module positional_ordered_list (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pol_pkg::CMD_W-1:0]        cmd,
  input  logic [pol_pkg::POS_W-1:0]        position,
  input  logic signed [pol_pkg::VAL_W-1:0] value,
  output logic                             done,
  output logic [pol_pkg::ST_W-1:0]         status,
  output logic signed [pol_pkg::VAL_W-1:0] removed_value,
  output logic [pol_pkg::OUT_W-1:0]        found_position,
  output logic [pol_pkg::OUT_W-1:0]        entry_count
);
  import pol_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0] cmd_q;
  logic [POS_W-1:0] pos_q;
  logic [VAL_W-1:0] val_q;
  logic [CNT_W-1:0] count, count_next;
  logic             rev;
  logic [ST_W-1:0]  status_q, st_exec;
  logic [VAL_W-1:0] removed_q, removed_exec;
  logic [CAPACITY-1:0] match, eq, valid_mask;

  logic [VAL_W-1:0] ent [CAPACITY];

  cell_op_t         op_exec;
  logic [CMP_W-1:0] cnt_x, pos_x, lpos, slot_x;
  cell_ctl_t        ctl;

  logic             accept;

  assign accept = start && !busy;
  assign busy   = (state == S_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_EXEC;
      S_EXEC:  state_next = S_DONE;
      S_DONE:  state_next = accept ? S_EXEC : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Decode the command against the count; positions are logical and get mapped
  // onto physical cells, mirrored when the orientation mark is set.
  always_comb begin
    cnt_x   = CMP_W'(count);
    pos_x   = CMP_W'(pos_q);
    op_exec = CO_HOLD;
    st_exec = ST_OK;
    lpos    = '0;
    case (cmd_q)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (cnt_x >= CMP_W'(CAPACITY)) begin
          st_exec = ST_FULL;
        end else begin
          op_exec = CO_INS;
          lpos    = (cmd_q == CMD_INS_HEAD) ? '0 : cnt_x;
        end
      end
      CMD_INS_POS: begin
        if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) begin
          st_exec = ST_BADPOS;
        end else if (cnt_x >= CMP_W'(CAPACITY)) begin
          st_exec = ST_FULL;
        end else begin
          op_exec = CO_INS;
          lpos    = pos_x - CMP_W'(1);
        end
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL: begin
        if (cnt_x == '0) begin
          st_exec = ST_EMPTY;
        end else begin
          op_exec = CO_DEL;
          lpos    = (cmd_q == CMD_DEL_HEAD) ? '0 : cnt_x - CMP_W'(1);
        end
      end
      CMD_DEL_POS: begin
        if (pos_x == '0) begin
          st_exec = ST_BADPOS;
        end else if (cnt_x == '0) begin
          st_exec = ST_EMPTY;
        end else if (pos_x > cnt_x) begin
          st_exec = ST_BADPOS;
        end else begin
          op_exec = CO_DEL;
          lpos    = pos_x - CMP_W'(1);
        end
      end
      default: st_exec = ST_OK;
    endcase

    if (!rev) begin
      slot_x = lpos;
    end else if (op_exec == CO_INS) begin
      slot_x = cnt_x - lpos;
    end else begin
      slot_x = cnt_x - CMP_W'(1) - lpos;
    end

    ctl.op    = (state == S_EXEC) ? op_exec : CO_HOLD;
    ctl.slot  = slot_x[IDX_W-1:0];
    ctl.value = val_q;

    removed_exec = (op_exec == CO_DEL) ? ent[slot_x[IDX_W-1:0]] : '0;

    case (ctl.op)
      CO_INS:  count_next = count + CNT_W'(1);
      CO_DEL:  count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase

    for (int i = 0; i < CAPACITY; i++) begin
      valid_mask[i] = (CMP_W'(i) < cnt_x);
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VAL_W-1:0] left_v, right_v;
      if (g == 0) begin : g_first
        assign left_v = ent[g];
      end else begin : g_mid_l
        assign left_v = ent[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_v = ent[g];
      end else begin : g_mid_r
        assign right_v = ent[g+1];
      end
      pol_cell u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .idx   (IDX_W'(g)),
        .left  (left_v),
        .right (right_v),
        .entry (ent[g]),
        .eq    (eq[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_EXEC && cmd_q == CMD_REVERSE) begin
        rev <= !rev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      pos_q <= position;
      val_q <= value;
    end
    if (state == S_EXEC) begin
      status_q  <= st_exec;
      removed_q <= removed_exec;
      match     <= eq & valid_mask;
    end
  end

  // Search result: the first match from the logical head, which is the highest
  // occupied cell when the orientation is mirrored.
  logic [IDX_W-1:0] lo_idx, hi_idx;
  logic [CMP_W-1:0] found_x;
  logic             any_match;

  always_comb begin
    lo_idx = '0;
    hi_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) lo_idx = IDX_W'(i);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) hi_idx = IDX_W'(i);
    end
    any_match = |match;
    if (!any_match) begin
      found_x = '0;
    end else if (rev) begin
      found_x = CMP_W'(count) - CMP_W'(hi_idx);
    end else begin
      found_x = CMP_W'(lo_idx) + CMP_W'(1);
    end
  end

  assign done          = (state == S_DONE);
  assign status        = (cmd_q == CMD_SEARCH) ? (any_match ? ST_OK : ST_NOTFOUND) : status_q;
  assign removed_value = removed_q;
  assign found_position = (cmd_q == CMD_SEARCH) ? OUT_W'(found_x) : '0;
  assign entry_count   = OUT_W'(count);

  `AST_IMPL(a_cnt_cap, 1'b1, count <= CNT_W'(CAPACITY), "count exceeds capacity")
  `AST_NEXT(a_exec_done, state == S_EXEC, done, "execute cycle not followed by a result beat")
  `AST_NEXT(a_accept_busy, accept, busy, "accepted command did not enter execute")
  `AST_NEXT(a_ins_cnt, ctl.op == CO_INS, count == $past(count) + CNT_W'(1),
            "insert did not raise the count by one")

endmodule

// ===== test/tb_positional_ordered_list.sv =====
// Self-checking testbench for the positional ordered list: directed and random command traffic.
module tb_positional_ordered_list;
  import pol_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] removed;
    logic [OUT_W-1:0] found;
    logic [OUT_W-1:0] count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        cmd = '0;
  logic [POS_W-1:0]        position = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    done;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] removed_value;
  logic [OUT_W-1:0]        found_position;
  logic [OUT_W-1:0]        entry_count;

  // Shadow copy of the list, head first.
  logic [VAL_W-1:0] list_mem [CAPACITY];
  int               list_len = 0;

  list_result_t pending_results [$];
  int           failure_count = 0;
  int           quiet_cycles = 0;
  int           gap_pct = 0;
  bit           growing = 1'b1;

  positional_ordered_list u_dut (
    clk,
    rst,
    start,
    busy,
    cmd,
    position,
    value,
    done,
    status,
    removed_value,
    found_position,
    entry_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void list_put(input int k, input logic [VAL_W-1:0] v);
    int j;
    for (j = list_len; j > k; j--) list_mem[j] = list_mem[j-1];
    list_mem[k] = v;
    list_len++;
  endfunction

  function automatic logic [VAL_W-1:0] list_take(input int k);
    logic [VAL_W-1:0] v;
    int               j;
    v = list_mem[k];
    for (j = k; j + 1 < list_len; j++) list_mem[j] = list_mem[j+1];
    list_len--;
    return v;
  endfunction

  // Applies one command to the shadow list and gives the result it should produce.
  function automatic list_result_t list_apply(input logic [CMD_W-1:0] c,
                                              input logic [POS_W-1:0] p,
                                              input logic [VAL_W-1:0] v);
    list_result_t     r;
    int               k;
    logic [VAL_W-1:0] t;
    r.status  = ST_OK;
    r.removed = '0;
    r.found   = '0;
    case (c)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (list_len >= CAPACITY) r.status = ST_FULL;
        else list_put((c == CMD_INS_HEAD) ? 0 : list_len, v);
      end
      CMD_INS_POS: begin
        // The position check takes precedence over the full check.
        if (p == 0 || int'(p) > list_len + 1) r.status = ST_BADPOS;
        else if (list_len >= CAPACITY) r.status = ST_FULL;
        else list_put(int'(p) - 1, v);
      end
      CMD_DEL_HEAD, CMD_DEL_TAIL: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.removed = list_take((c == CMD_DEL_HEAD) ? 0 : list_len - 1);
      end
      CMD_DEL_POS: begin
        if (p == 0) r.status = ST_BADPOS;
        else if (list_len == 0) r.status = ST_EMPTY;
        else if (int'(p) > list_len) r.status = ST_BADPOS;
        else r.removed = list_take(int'(p) - 1);
      end
      CMD_SEARCH: begin
        r.status = ST_NOTFOUND;
        for (k = 0; k < list_len; k++) begin
          if (r.status == ST_NOTFOUND && list_mem[k] == v) begin
            r.status = ST_OK;
            r.found  = OUT_W'(k + 1);
          end
        end
      end
      default: begin
        for (k = 0; k < list_len / 2; k++) begin
          t                      = list_mem[k];
          list_mem[k]            = list_mem[list_len-1-k];
          list_mem[list_len-1-k] = t;
        end
      end
    endcase
    r.count = OUT_W'(list_len);
    return r;
  endfunction

  function automatic void report_failure(input string msg);
    failure_count++;
    if (failure_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  // Drives one command beat and records what it should produce once it is taken.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                           input logic [VAL_W-1:0] v);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start    = 1'b1;
    cmd      = c;
    position = p;
    value    = v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(list_apply(c, p, v));
  endtask

  always @(posedge clk) begin : result_check
    list_result_t want;
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_failure("result beat with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || removed_value !== want.removed ||
            found_position !== want.found || entry_count !== want.count)
          report_failure($sformatf({"exp status %0d removed %h found %0d count %0d, ",
                                    "got status %0d removed %h found %0d count %0d"},
                                   want.status, want.removed, want.found, want.count,
                                   status, removed_value, found_position, entry_count));
      end
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
      3, 4:    return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_insert();
    case ($urandom_range(0, 2))
      0:       return CMD_INS_HEAD;
      1:       return CMD_INS_TAIL;
      default: return CMD_INS_POS;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_delete();
    case ($urandom_range(0, 2))
      0:       return CMD_DEL_HEAD;
      1:       return CMD_DEL_TAIL;
      default: return CMD_DEL_POS;
    endcase
  endfunction

  task automatic test_empty_list();
    send_item(CMD_DEL_HEAD, 5'd0, 32'd0);
    send_item(CMD_DEL_TAIL, 5'd0, 32'd0);
    send_item(CMD_DEL_POS, 5'd0, 32'd0);
    send_item(CMD_DEL_POS, 5'd31, 32'd0);
    send_item(CMD_SEARCH, 5'd0, 32'd0);
    send_item(CMD_REVERSE, 5'd0, 32'd0);
    send_item(CMD_INS_POS, 5'd0, 32'd9);
    send_item(CMD_INS_POS, 5'd2, 32'd9);
  endtask

  task automatic test_insert_positions();
    // Position one on an empty list is one past the tail, so it appends.
    send_item(CMD_INS_POS, 5'd1, 32'd7);
    send_item(CMD_REVERSE, 5'd0, 32'd0);
    send_item(CMD_INS_HEAD, 5'd0, 32'h7fff_ffff);
    send_item(CMD_INS_TAIL, 5'd0, 32'h8000_0000);
    send_item(CMD_INS_POS, 5'd4, 32'hffff_ffff);
    send_item(CMD_INS_POS, 5'd2, 32'd7);
    send_item(CMD_INS_POS, 5'd31, 32'd5);
  endtask

  task automatic test_search_first_match();
    send_item(CMD_SEARCH, 5'd0, 32'd7);
    send_item(CMD_SEARCH, 5'd31, 32'h8000_0000);
    send_item(CMD_SEARCH, 5'd0, 32'd12345);
  endtask

  task automatic test_reverse_order();
    send_item(CMD_REVERSE, 5'd0, 32'd0);
    send_item(CMD_SEARCH, 5'd0, 32'd7);
    send_item(CMD_SEARCH, 5'd0, 32'h7fff_ffff);
  endtask

  task automatic test_delete_positions();
    send_item(CMD_DEL_POS, 5'd6, 32'd0);
    send_item(CMD_DEL_POS, 5'd5, 32'd0);
    send_item(CMD_DEL_POS, 5'd1, 32'd0);
    send_item(CMD_DEL_TAIL, 5'd0, 32'd0);
    send_item(CMD_DEL_HEAD, 5'd0, 32'd0);
    send_item(CMD_DEL_POS, 5'd1, 32'd0);
    send_item(CMD_DEL_POS, 5'd1, 32'd0);
  endtask

  // Mostly well-formed traffic that swings the list between empty and full,
  // with a share of fully random commands mixed in.
  task automatic test_random_traffic(input int idle_pct, input int n_items);
    logic [CMD_W-1:0] c;
    logic [POS_W-1:0] p;
    logic [VAL_W-1:0] v;
    int               roll;
    int               i;
    gap_pct = idle_pct;
    for (i = 0; i < n_items; i++) begin
      p = POS_W'($urandom);
      v = pick_value();
      if ($urandom_range(0, 99) < 12) begin
        c = CMD_W'($urandom_range(0, 7));
      end else begin
        if (growing && list_len == CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
        else if (!growing && list_len == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 65) c = growing ? pick_insert() : pick_delete();
        else if (roll < 80) c = growing ? pick_delete() : pick_insert();
        else if (roll < 93) c = CMD_SEARCH;
        else c = CMD_REVERSE;
        if (c == CMD_INS_POS) p = POS_W'($urandom_range(1, list_len + 1));
        else if (c == CMD_DEL_POS && list_len > 0) p = POS_W'($urandom_range(1, list_len));
        if (c == CMD_SEARCH && list_len > 0 && $urandom_range(0, 9) < 6)
          v = list_mem[$urandom_range(0, list_len - 1)];
      end
      send_item(c, p, v);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    gap_pct = 18;
    test_empty_list();
    test_insert_positions();
    test_search_first_match();
    test_reverse_order();
    test_delete_positions();
    test_random_traffic(18, 550);
    test_random_traffic(60, 550);
    test_random_traffic(0, 550);
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Keep the clock running so that any stray beat is caught.
    repeat (8) @(posedge clk);
    if (failure_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
